/* rtl/core/sorted_priority_queue_core_defines.svh */
// Assertion macros shared by the sorted priority queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

/* rtl/core/spq_pkg.sv */
// Types and constants for the sorted priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PRI_LEVELS      = 16;
  localparam int TAG_BITS        = 16;

  localparam int PRI_W  = 4;
  localparam int TAG_W  = 16;
  localparam int FILL_W = 5;

  localparam logic [PRI_W-1:0] PRI_MAX  = PRI_W'(PRI_LEVELS - 1);
  localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((33'd1 << TAG_BITS) - 33'd1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PRI_W-1:0] entry_priority;
    logic [TAG_W-1:0] entry_tag;
  } spq_in_t;

  typedef struct packed {
    logic              got_entry;
    logic [TAG_W-1:0]  out_tag;
    logic [PRI_W-1:0]  out_priority;
    logic              insert_dropped;
    logic [FILL_W-1:0] fill_count;
  } spq_out_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } spq_entry_t;

  typedef struct packed {
    logic load;
    logic rd_head;
    logic ins_init;
    logic ins_shift;
    logic ins_place;
    logic fin_insert;
    logic fin_remove;
    logic fin_drop;
    logic fin_empty;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic lower;
    logic idx_one;
  } spq_sts_t;

endpackage

`default_nettype wire

/* rtl/core/spq_ctrl.sv */
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives the datapath through command and status structs.
`default_nettype none

module spq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire              kind,
  input  spq_pkg::spq_sts_t sts,
  output logic             busy,
  output spq_pkg::spq_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_INS_START = 5'b00010,
    S_INS_CMP   = 5'b00100,
    S_INS_PLACE = 5'b01000,
    S_REM_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (kind == spq_pkg::KIND_INSERT) begin
            if (sts.full) begin
              cmd.fin_drop = 1'b1;
            end else begin
              state_nxt = S_INS_START;
            end
          end else begin
            if (sts.empty) begin
              cmd.fin_empty = 1'b1;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_REM_OUT;
            end
          end
        end
      end
      S_INS_START: begin
        cmd.ins_init = 1'b1;
        state_nxt    = sts.empty ? S_INS_PLACE : S_INS_CMP;
      end
      S_INS_CMP: begin
        if (sts.lower) begin
          cmd.ins_shift = 1'b1;
          if (sts.idx_one) begin
            state_nxt = S_INS_PLACE;
          end
        end else begin
          cmd.ins_place  = 1'b1;
          cmd.fin_insert = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_INS_PLACE: begin
        cmd.ins_place  = 1'b1;
        cmd.fin_insert = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_REM_OUT: begin
        cmd.fin_remove = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/spq_dpath.sv */
// Datapath of the sorted priority queue: circular entry memory, pointers and result register.
// Depends on spq_pkg and sorted_priority_queue_core_defines.svh; driven by spq_ctrl.
`default_nettype none
`include "sorted_priority_queue_core_defines.svh"

module spq_dpath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  spq_pkg::spq_in_t  in_item,
  input  spq_pkg::spq_cmd_t cmd,
  output spq_pkg::spq_sts_t sts,
  output logic              out_valid,
  output spq_pkg::spq_out_t out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  spq_pkg::spq_entry_t mem [QUEUE_DEPTH];

  spq_pkg::spq_entry_t item_r, rd_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] wp_prev, wp_nxt_prev, rd_addr;
  logic          out_valid_r;
  spq_pkg::spq_out_t out_item_r, out_item_nxt;
  logic [31:0]   count_wide;
  logic [spq_pkg::PRI_W-1:0] pri_in;

  always_comb begin
    wp_prev     = (wp_r == '0) ? LAST : wp_r - AW'(1);
    wp_nxt      = cmd.ins_init ? tail_r : (cmd.ins_shift ? wp_prev : wp_r);
    wp_nxt_prev = (wp_nxt == '0) ? LAST : wp_nxt - AW'(1);
    rd_addr     = cmd.rd_head ? head_r : wp_nxt_prev;
    idx_nxt     = cmd.ins_init ? count_r : (cmd.ins_shift ? idx_r - CW'(1) : idx_r);

    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.fin_insert) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + AW'(1);
      count_nxt = count_r + CW'(1);
    end
    if (cmd.fin_remove) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end

    count_wide   = 32'(count_nxt);
    out_item_nxt = '0;
    out_item_nxt.fill_count = count_wide[spq_pkg::FILL_W-1:0];
    if (cmd.fin_remove) begin
      out_item_nxt.got_entry    = 1'b1;
      out_item_nxt.out_tag      = rd_r.tag;
      out_item_nxt.out_priority = rd_r.pri;
    end
    if (cmd.fin_drop) begin
      out_item_nxt.insert_dropped = 1'b1;
    end

    pri_in = (in_item.entry_priority > spq_pkg::PRI_MAX) ? spq_pkg::PRI_MAX
                                                          : in_item.entry_priority;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.fin_insert | cmd.fin_remove | cmd.fin_drop | cmd.fin_empty;
    end
  end

  always_ff @(posedge clk) begin
    wp_r  <= wp_nxt;
    idx_r <= idx_nxt;
    if (cmd.load) begin
      item_r.pri <= pri_in;
      item_r.tag <= in_item.entry_tag & spq_pkg::TAG_MASK;
    end
    if (cmd.fin_insert | cmd.fin_remove | cmd.fin_drop | cmd.fin_empty) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (cmd.ins_shift) begin
      mem[wp_r] <= rd_r;
    end else if (cmd.ins_place) begin
      mem[wp_r] <= item_r;
    end
  end

  assign sts.full    = (count_r == FULL);
  assign sts.empty   = (count_r == '0);
  assign sts.lower   = (rd_r.pri < item_r.pri);
  assign sts.idx_one = (idx_r == CW'(1));

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SPQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL)
  `SPQ_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, count_r == '0, head_r == tail_r)
  `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.fin_insert, count_r == $past(count_r) + CW'(1))
  `SPQ_ASSERT_NEXT(a_remove_gives, clk, rst_n, cmd.fin_remove, out_valid_r && out_item_r.got_entry)

endmodule

`default_nettype wire

/* rtl/core/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: joins the controller and the datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
// Usage: an item on in_item is taken at a rising edge where start is high and busy
// is low. An insert item places entry_tag with entry_priority behind every held entry
// of greater or equal priority; a remove item pops the head of the queue.
// Every item gives one result on out_item, shown for exactly one cycle with out_valid
// high; the receiver cannot hold it off and must take it in that cycle.
// An insert keeps busy high while it walks back from the tail over every held entry of lower
// priority, one entry a cycle, because the entry memory has one read and one write port.
// A remove keeps busy high for the registered read of the head entry.
// An insert into a full queue and a remove from an empty queue leave busy low.
// The result is shown in the first cycle in which busy is low again, or in the cycle
// after acceptance when busy stays low, and the next item may be accepted in that cycle.
// Reset empties the queue at once; the entry memory itself is not cleared, since only
// held entries are ever read.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  spq_pkg::spq_in_t  in_item,
  output logic              out_valid,
  output spq_pkg::spq_out_t out_item
);

  spq_pkg::spq_cmd_t cmd;
  spq_pkg::spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_item.kind),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  spq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
